// ----- rtl/utf8x_pkg.sv -----
package utf8x_pkg;

  localparam int OFFSET_WIDTH = 32;
  localparam int LOC_WIDTH    = 32;
  localparam int CP_WIDTH     = 21;

  localparam logic [7:0] LEAD2_MIN = 8'hc2;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD4_MAX = 8'hf4;

  localparam logic [CP_WIDTH-1:0] CP_MIN3      = 21'h000800;
  localparam logic [CP_WIDTH-1:0] CP_MIN4      = 21'h010000;
  localparam logic [CP_WIDTH-1:0] CP_SURR_LO   = 21'h00d800;
  localparam logic [CP_WIDTH-1:0] CP_SURR_HI   = 21'h00dfff;
  localparam logic [CP_WIDTH-1:0] CP_MAX       = 21'h10ffff;
  localparam logic [CP_WIDTH-1:0] CP_TAB       = 21'h000009;
  localparam logic [CP_WIDTH-1:0] CP_LF        = 21'h00000a;
  localparam logic [CP_WIDTH-1:0] CP_CR        = 21'h00000d;
  localparam logic [CP_WIDTH-1:0] CP_SPACE     = 21'h000020;
  localparam logic [CP_WIDTH-1:0] CP_BMP_LO_HI = 21'h00d7ff;
  localparam logic [CP_WIDTH-1:0] CP_BMP_HI_LO = 21'h00e000;
  localparam logic [CP_WIDTH-1:0] CP_BMP_HI_HI = 21'h00fffd;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_BAD_CHAR  = 2'd2
  } status_t;

  function automatic logic xml_char_ok(input logic [CP_WIDTH-1:0] cp);
    xml_char_ok = (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
                  (cp >= CP_SPACE && cp <= CP_BMP_LO_HI) ||
                  (cp >= CP_BMP_HI_LO && cp <= CP_BMP_HI_HI) ||
                  (cp >= CP_MIN4 && cp <= CP_MAX);
  endfunction

  function automatic logic cp_value_bad(input logic [CP_WIDTH-1:0] cp,
                                        input logic [2:0] width);
    cp_value_bad = (width == 3'd3 && cp < CP_MIN3) ||
                   (width == 3'd4 && cp < CP_MIN4) ||
                   (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ||
                   (cp > CP_MAX);
  endfunction

endpackage

// ----- rtl/utf8_xml_char_validator.sv -----
// Channel  | Direction | Contents
// s_axis   | in        | tdata: data_byte [7:0]; tlast: last
// m_axis   | out       | tuser: status [1:0]; tdata: error_offset [31:0],
//          |           |   error_line [63:32], error_column [95:64]
//
// One byte is taken per cycle while s_axis_tready is high; the decoder state
// and location counters are updated in the cycle a byte is accepted.
// A result appears in the output register in the cycle after the final byte.
// The input stalls only while a result is held and m_axis_tready is low.
// Reset is synchronous and returns every counter to the start of a document.
module utf8_xml_char_validator
  import utf8x_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // error_offset, error_line, error_column
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  logic                    in_accept;
  logic [7:0]              b;

  logic [1:0]              bytes_left, bytes_left_next;
  logic [2:0]              seq_width, seq_width_next;
  logic [CP_WIDTH-1:0]     code_value, code_value_next;
  logic [OFFSET_WIDTH-1:0] cur_offset, cur_offset_next;
  logic [LOC_WIDTH-1:0]    cur_line, cur_line_next;
  logic [LOC_WIDTH-1:0]    cur_column, cur_column_next;
  logic [OFFSET_WIDTH-1:0] start_offset, start_offset_next;
  logic [LOC_WIDTH-1:0]    start_line, start_line_next;
  logic [LOC_WIDTH-1:0]    start_column, start_column_next;
  status_t                 first_error, first_error_next;
  logic [OFFSET_WIDTH-1:0] err_offset, err_offset_next;
  logic [LOC_WIDTH-1:0]    err_line, err_line_next;
  logic [LOC_WIDTH-1:0]    err_column, err_column_next;

  logic                    finish_req;
  logic [CP_WIDTH-1:0]     fin_cp;
  logic [2:0]              fin_width;
  status_t                 err_code;
  logic [OFFSET_WIDTH:0]   off_sum;
  logic [LOC_WIDTH:0]      col_sum;

  status_t                 res_status, res_status_next;
  logic [31:0]             res_offset, res_offset_next;
  logic [LOC_WIDTH-1:0]    res_line, res_line_next;
  logic [LOC_WIDTH-1:0]    res_column, res_column_next;
  logic                    res_valid;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !res_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign off_sum = {1'b0, cur_offset} + (OFFSET_WIDTH + 1)'(fin_width);
  assign col_sum = {1'b0, cur_column} + (LOC_WIDTH + 1)'(fin_width);

  always_comb begin
    bytes_left_next   = bytes_left;
    seq_width_next    = seq_width;
    code_value_next   = code_value;
    cur_offset_next   = cur_offset;
    cur_line_next     = cur_line;
    cur_column_next   = cur_column;
    start_offset_next = start_offset;
    start_line_next   = start_line;
    start_column_next = start_column;
    first_error_next  = first_error;
    err_offset_next   = err_offset;
    err_line_next     = err_line;
    err_column_next   = err_column;
    finish_req        = 1'b0;
    fin_cp            = code_value;
    fin_width         = seq_width;
    err_code          = ST_OK;
    res_status_next   = res_status;
    res_offset_next   = res_offset;
    res_line_next     = res_line;
    res_column_next   = res_column;

    if (in_accept && first_error == ST_OK) begin
      if (bytes_left == 2'd0) begin
        start_offset_next = cur_offset;
        start_line_next   = cur_line;
        start_column_next = cur_column;
        if (!b[7]) begin
          seq_width_next  = 3'd1;
          code_value_next = {13'd0, b};
          finish_req      = 1'b1;
          fin_cp          = {13'd0, b};
          fin_width       = 3'd1;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          seq_width_next  = 3'd2;
          code_value_next = {16'd0, b[4:0]};
          bytes_left_next = 2'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          seq_width_next  = 3'd3;
          code_value_next = {17'd0, b[3:0]};
          bytes_left_next = 2'd2;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          seq_width_next  = 3'd4;
          code_value_next = {18'd0, b[2:0]};
          bytes_left_next = 2'd3;
        end else begin
          err_code = ST_MALFORMED;
        end
      end else if (b[7:6] != 2'b10) begin
        err_code = ST_MALFORMED;
      end else begin
        code_value_next = {code_value[CP_WIDTH-7:0], b[5:0]};
        bytes_left_next = bytes_left - 2'd1;
        if (bytes_left == 2'd1) begin
          finish_req = 1'b1;
          fin_cp     = {code_value[CP_WIDTH-7:0], b[5:0]};
          fin_width  = seq_width;
        end
      end
    end

    if (finish_req) begin
      if (cp_value_bad(fin_cp, fin_width)) begin
        err_code = ST_MALFORMED;
      end else if (!xml_char_ok(fin_cp)) begin
        err_code = ST_BAD_CHAR;
      end else begin
        cur_offset_next = off_sum[OFFSET_WIDTH] ? '1 : off_sum[OFFSET_WIDTH-1:0];
        if (fin_cp == CP_LF) begin
          cur_line_next   = (cur_line == '1) ? cur_line : cur_line + 1'b1;
          cur_column_next = LOC_WIDTH'(1);
        end else begin
          cur_column_next = col_sum[LOC_WIDTH] ? '1 : col_sum[LOC_WIDTH-1:0];
        end
      end
    end

    if (err_code != ST_OK) begin
      first_error_next = err_code;
      err_offset_next  = start_offset_next;
      err_line_next    = start_line_next;
      err_column_next  = start_column_next;
      bytes_left_next  = 2'd0;
    end

    if (in_accept && s_axis_tlast) begin
      if (first_error_next == ST_OK && bytes_left_next != 2'd0) begin
        first_error_next = ST_MALFORMED;
        err_offset_next  = start_offset_next;
        err_line_next    = start_line_next;
        err_column_next  = start_column_next;
      end
      res_status_next = first_error_next;
      if (first_error_next != ST_OK) begin
        res_offset_next = 32'(err_offset_next);
        res_line_next   = err_line_next;
        res_column_next = err_column_next;
      end else begin
        res_offset_next = '0;
        res_line_next   = '0;
        res_column_next = '0;
      end
      bytes_left_next   = 2'd0;
      seq_width_next    = 3'd0;
      code_value_next   = '0;
      cur_offset_next   = '0;
      cur_line_next     = LOC_WIDTH'(1);
      cur_column_next   = LOC_WIDTH'(1);
      start_offset_next = '0;
      start_line_next   = LOC_WIDTH'(1);
      start_column_next = LOC_WIDTH'(1);
      first_error_next  = ST_OK;
      err_offset_next   = '0;
      err_line_next     = '0;
      err_column_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= 2'd0;
      seq_width    <= 3'd0;
      code_value   <= '0;
      cur_offset   <= '0;
      cur_line     <= LOC_WIDTH'(1);
      cur_column   <= LOC_WIDTH'(1);
      start_offset <= '0;
      start_line   <= LOC_WIDTH'(1);
      start_column <= LOC_WIDTH'(1);
      first_error  <= ST_OK;
      err_offset   <= '0;
      err_line     <= '0;
      err_column   <= '0;
      res_valid    <= 1'b0;
    end else begin
      bytes_left   <= bytes_left_next;
      seq_width    <= seq_width_next;
      code_value   <= code_value_next;
      cur_offset   <= cur_offset_next;
      cur_line     <= cur_line_next;
      cur_column   <= cur_column_next;
      start_offset <= start_offset_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
      first_error  <= first_error_next;
      err_offset   <= err_offset_next;
      err_line     <= err_line_next;
      err_column   <= err_column_next;
      if (in_accept && s_axis_tlast) begin
        res_valid <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_offset <= res_offset_next;
    res_line   <= res_line_next;
    res_column <= res_column_next;
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_status;
  assign m_axis_tdata  = {res_column, res_line, res_offset};

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result appeared without a final byte request");

  a_ok_zero_location: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_status == ST_OK) |-> (m_axis_tdata == '0))
    else $error("clean document reported a non-zero location");

  a_error_location: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_status != ST_OK) |-> (res_line != '0 && res_column != '0))
    else $error("error reported with a zero line or column");

  a_no_decode_after_error: assert property (@(posedge clk) disable iff (rst)
    (bytes_left != 2'd0) |-> (first_error == ST_OK))
    else $error("sequence still open after an error was recorded");

  a_width_consistent: assert property (@(posedge clk) disable iff (rst)
    (bytes_left != 2'd0) |-> (seq_width > {1'b0, bytes_left} && seq_width <= 3'd4))
    else $error("continuation count does not match the sequence width");

endmodule

// ----- test/tb_utf8_xml_char_validator.sv -----
module tb_utf8_xml_char_validator;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8x_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 1550;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_ALL = {OFFSET_WIDTH{1'b1}};
  localparam logic [31:0] LOC_ALL = 32'hffff_ffff;

  typedef enum int {
    F_BAD_LEAD,
    F_BAD_CONT,
    F_OVERLONG3,
    F_OVERLONG4,
    F_SURROGATE,
    F_TOO_BIG,
    F_BAD_XML,
    F_CUT_OFF
  } fault_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       hold;
  } byte_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [31:0] line;
    logic [31:0] column;
  } doc_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  utf8_xml_char_validator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  byte_req_t   pending_bytes[$];
  doc_report_t expected_reports[$];
  logic [7:0]  doc_bytes[$];
  int          live_bytes = 0;
  int          mismatches = 0;
  int          reports_seen = 0;
  int          cycle_count = 0;

  // Decoder state of the checker, mirroring the document being streamed.
  logic [1:0]              need_cnt;
  logic [2:0]              seq_len;
  logic [CP_WIDTH-1:0]     cp_acc;
  logic [OFFSET_WIDTH-1:0] pos_offset;
  logic [31:0]             pos_line;
  logic [31:0]             pos_col;
  logic [OFFSET_WIDTH-1:0] lead_offset;
  logic [31:0]             lead_line;
  logic [31:0]             lead_col;
  status_t                 err_kind;
  logic [OFFSET_WIDTH-1:0] err_off;
  logic [31:0]             err_line;
  logic [31:0]             err_col;

  task automatic clear_tracker();
    need_cnt    = 2'd0;
    seq_len     = 3'd0;
    cp_acc      = '0;
    pos_offset  = '0;
    pos_line    = 32'd1;
    pos_col     = 32'd1;
    lead_offset = '0;
    lead_line   = 32'd1;
    lead_col    = 32'd1;
    err_kind    = ST_OK;
    err_off     = '0;
    err_line    = 32'd0;
    err_col     = 32'd0;
  endtask

  task automatic note_error(input status_t kind);
    if (err_kind == ST_OK) begin
      err_kind = kind;
      err_off  = lead_offset;
      err_line = lead_line;
      err_col  = lead_col;
    end
    need_cnt = 2'd0;
  endtask

  function automatic logic legal_xml_cp(input logic [CP_WIDTH-1:0] cp);
    if (cp < CP_SPACE)
      return cp == CP_TAB || cp == CP_LF || cp == CP_CR;
    if (cp <= CP_BMP_LO_HI)
      return 1'b1;
    if (cp < CP_BMP_HI_LO)
      return 1'b0;
    if (cp <= CP_BMP_HI_HI)
      return 1'b1;
    return cp >= CP_MIN4 && cp <= CP_MAX;
  endfunction

  task automatic close_char();
    if (cp_acc > CP_MAX || (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI) ||
        (seq_len == 3'd4 && cp_acc < CP_MIN4) || (seq_len == 3'd3 && cp_acc < CP_MIN3)) begin
      note_error(ST_MALFORMED);
    end else if (!legal_xml_cp(cp_acc)) begin
      note_error(ST_BAD_CHAR);
    end else begin
      if (pos_offset > OFFSET_ALL - seq_len) pos_offset = OFFSET_ALL;
      else pos_offset = pos_offset + seq_len;
      if (cp_acc == CP_LF) begin
        if (pos_line != LOC_ALL) pos_line = pos_line + 32'd1;
        pos_col = 32'd1;
      end else if (pos_col > LOC_ALL - seq_len) begin
        pos_col = LOC_ALL;
      end else begin
        pos_col = pos_col + seq_len;
      end
    end
  endtask

  task automatic track_byte(input logic [7:0] b, input logic fin);
    doc_report_t rep;
    if (err_kind == ST_OK) begin
      if (need_cnt == 2'd0) begin
        lead_offset = pos_offset;
        lead_line   = pos_line;
        lead_col    = pos_col;
        if (b <= 8'h7f) begin
          seq_len = 3'd1;
          cp_acc  = CP_WIDTH'(b);
          close_char();
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          seq_len  = 3'd2;
          cp_acc   = CP_WIDTH'(b[4:0]);
          need_cnt = 2'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          seq_len  = 3'd3;
          cp_acc   = CP_WIDTH'(b[3:0]);
          need_cnt = 2'd2;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          seq_len  = 3'd4;
          cp_acc   = CP_WIDTH'(b[2:0]);
          need_cnt = 2'd3;
        end else begin
          note_error(ST_MALFORMED);
        end
      end else if (b[7:6] != 2'b10) begin
        note_error(ST_MALFORMED);
      end else begin
        cp_acc   = {cp_acc[CP_WIDTH-7:0], b[5:0]};
        need_cnt = need_cnt - 2'd1;
        if (need_cnt == 2'd0) close_char();
      end
    end
    if (fin) begin
      if (err_kind == ST_OK && need_cnt != 2'd0) note_error(ST_MALFORMED);
      rep.status = err_kind;
      rep.offset = (err_kind == ST_OK) ? 32'd0 : 32'(err_off);
      rep.line   = (err_kind == ST_OK) ? 32'd0 : err_line;
      rep.column = (err_kind == ST_OK) ? 32'd0 : err_col;
      expected_reports.push_back(rep);
      clear_tracker();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", reports_seen, what);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stimulus building.

  task automatic put_seq(input logic [CP_WIDTH-1:0] cp, input int len);
    case (len)
      1: doc_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        doc_bytes.push_back({3'b110, cp[10:6]});
        doc_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        doc_bytes.push_back({4'b1110, cp[15:12]});
        doc_bytes.push_back({2'b10, cp[11:6]});
        doc_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        doc_bytes.push_back({5'b11110, cp[20:18]});
        doc_bytes.push_back({2'b10, cp[17:12]});
        doc_bytes.push_back({2'b10, cp[11:6]});
        doc_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
    live_bytes += len;
  endtask

  task automatic put_cp(input logic [CP_WIDTH-1:0] cp);
    if (cp < 21'h80) put_seq(cp, 1);
    else if (cp < CP_MIN3) put_seq(cp, 2);
    else if (cp < CP_MIN4) put_seq(cp, 3);
    else put_seq(cp, 4);
  endtask

  function automatic logic [CP_WIDTH-1:0] rand_cp_of(input int len);
    case (len)
      2: return CP_WIDTH'($urandom_range(21'h80, 21'h7ff));
      3: return CP_WIDTH'($urandom_range(0, 1) ? $urandom_range(CP_MIN3, CP_BMP_LO_HI)
                                               : $urandom_range(CP_BMP_HI_LO, CP_BMP_HI_HI));
      default: return CP_WIDTH'($urandom_range(CP_MIN4, CP_MAX));
    endcase
  endfunction

  task automatic put_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) begin
      put_cp(CP_WIDTH'($urandom_range(CP_SPACE, 21'h7e)));
    end else if (r < 11) begin
      put_cp(CP_LF);
    end else if (r == 11) begin
      put_cp($urandom_range(0, 1) ? CP_TAB : CP_CR);
    end else if (r < 18) begin
      put_cp(rand_cp_of($urandom_range(2, 4)));
    end else begin
      case ($urandom_range(0, 9))
        0: put_cp(CP_SPACE);
        1: put_cp(21'h7f);
        2: put_cp(21'h80);
        3: put_cp(21'h7ff);
        4: put_cp(CP_MIN3);
        5: put_cp(CP_BMP_LO_HI);
        6: put_cp(CP_BMP_HI_LO);
        7: put_cp(CP_BMP_HI_HI);
        8: put_cp(CP_MIN4);
        default: put_cp(CP_MAX);
      endcase
    end
  endtask

  task automatic put_fault(input fault_t fault);
    int len;
    logic [7:0] c;
    len = $urandom_range(2, 4);
    case (fault)
      F_BAD_LEAD: begin
        doc_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hc1)
                                                    : $urandom_range(8'hf5, 8'hff)));
        live_bytes++;
      end
      F_BAD_CONT: begin
        put_seq(rand_cp_of(len), len);
        c = 8'($urandom_range(0, 1) ? $urandom_range(8'h00, 8'h7f)
                                    : $urandom_range(8'hc0, 8'hff));
        doc_bytes[doc_bytes.size() - $urandom_range(1, len - 1)] = c;
      end
      F_OVERLONG3: put_seq(CP_WIDTH'($urandom_range(0, 21'h7ff)), 3);
      F_OVERLONG4: put_seq(CP_WIDTH'($urandom_range(0, 21'hffff)), 4);
      F_SURROGATE: put_seq(CP_WIDTH'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
      F_TOO_BIG:   put_seq(CP_WIDTH'($urandom_range(21'h110000, 21'h13ffff)), 4);
      F_BAD_XML: begin
        if ($urandom_range(0, 3) == 0) begin
          put_seq(CP_WIDTH'($urandom_range(21'hfffe, 21'hffff)), 3);
        end else begin
          c = 8'($urandom_range(0, 31));
          if (c == CP_TAB || c == CP_LF || c == CP_CR) c = 8'h0b;
          put_seq(CP_WIDTH'(c), 1);
        end
      end
      default: begin
        put_seq(rand_cp_of(len), len);
        repeat ($urandom_range(1, len - 1)) begin
          void'(doc_bytes.pop_back());
          live_bytes--;
        end
      end
    endcase
  endtask

  task automatic flush_doc(input logic hold);
    byte_req_t req;
    for (int i = 0; i < doc_bytes.size(); i++) begin
      req.data = doc_bytes[i];
      req.fin  = (i == doc_bytes.size() - 1);
      req.hold = hold && (i == 0);
      pending_bytes.push_back(req);
    end
    doc_bytes.delete();
  endtask

  task automatic gen_doc();
    int r;
    int n_cp;
    int bad_at;
    fault_t fault;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      repeat ($urandom_range(1, 16)) begin
        doc_bytes.push_back(8'($urandom_range(0, 255)));
        live_bytes++;
      end
    end else begin
      n_cp   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      bad_at = (r <= 3) ? $urandom_range(0, n_cp - 1) : -1;
      fault  = fault_t'($urandom_range(0, 7));
      for (int i = 0; i < n_cp; i++) begin
        if (i == bad_at) begin
          put_fault(fault);
          if (fault != F_CUT_OFF)
            repeat ($urandom_range(0, 4)) begin
              doc_bytes.push_back(8'($urandom_range(0, 255)));
              live_bytes++;
            end
          break;
        end
        put_char();
      end
    end
    flush_doc($urandom_range(0, 14) == 0);
  endtask

  // Request driver.
  int send_gap = 0;
  int send_quiet = 0;

  always @(posedge clk) begin
    byte_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].hold && expected_reports.size() != 0)) begin
          req = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.data;
          s_axis_tlast  <= req.fin;
          if (send_quiet != 0) send_quiet--;
          else if ($urandom_range(0, 3) == 0) send_gap = pick_gap();
          else if ($urandom_range(0, 149) == 0) send_quiet = $urandom_range(30, 120);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  int recv_stall = 0;
  int recv_quiet = 0;

  always @(posedge clk) begin
    doc_report_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          report_mismatch("result with none expected");
        end else begin
          want = expected_reports.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
          if (m_axis_tdata[31:0] !== want.offset)
            report_mismatch($sformatf("offset %0d, expected %0d",
                                      m_axis_tdata[31:0], want.offset));
          if (m_axis_tdata[63:32] !== want.line)
            report_mismatch($sformatf("line %0d, expected %0d", m_axis_tdata[63:32], want.line));
          if (m_axis_tdata[95:64] !== want.column)
            report_mismatch($sformatf("column %0d, expected %0d",
                                      m_axis_tdata[95:64], want.column));
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_quiet != 0) recv_quiet--;
        else if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
        else if ($urandom_range(0, 199) == 0) recv_quiet = $urandom_range(50, 200);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_tracker();

    doc_bytes = {8'h41};
    flush_doc(1'b0);
    doc_bytes = {8'h00};
    flush_doc(1'b1);
    doc_bytes = {8'h61, 8'h0a, 8'h62, 8'hff};
    flush_doc(1'b0);
    doc_bytes = {8'he0, 8'h9f, 8'hbf};
    flush_doc(1'b0);
    doc_bytes = {8'h09, 8'hed, 8'ha0, 8'h80};
    flush_doc(1'b0);
    doc_bytes = {8'hf4, 8'h90, 8'h80, 8'h80};
    flush_doc(1'b0);
    doc_bytes = {8'hc3, 8'h41};
    flush_doc(1'b0);
    doc_bytes = {8'hf0, 8'h9f, 8'h98};
    flush_doc(1'b0);
    doc_bytes = {8'hf4, 8'h8f, 8'hbf, 8'hbf};
    flush_doc(1'b0);

    while (live_bytes < RANDOM_BYTES) gen_doc();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
